// ----- src/ipid_pkg.sv -----
// ipid_pkg: shared widths, register codes and the configuration struct
// for the incremental PID block with deadband.
// No dependencies; used by ipid_regs, ipid_core and the top level.
package ipid_pkg;

  // Default number of fraction bits in gains and accumulator
  localparam int FRAC_BITS_DEF = 16;

  // Field widths
  localparam int DATA_W = 16;            // measured, setpoint, drive
  localparam int ERR_W  = DATA_W + 1;    // setpoint - measured
  localparam int D1_W   = ERR_W + 1;     // first difference
  localparam int D2_W   = ERR_W + 2;     // second difference
  localparam int GAIN_W = 24;            // Q8.F gains
  localparam int LIM_W  = 15;            // output and integral limits
  localparam int DB_W   = 16;            // deadband
  localparam int P_W    = GAIN_W + D1_W; // Kp * d1
  localparam int I_W    = GAIN_W + ERR_W;// Ki * err
  localparam int D_W    = GAIN_W + D2_W; // Kd * d2
  localparam int SUM_W  = D_W + 3;       // acc + P + I + D, no overflow

  // Configuration port
  localparam int CFG_DW = 32;
  localparam int CFG_AW = 5;
  localparam int IDX_W  = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_KP   = 3'd0,
    REG_KI   = 3'd1,
    REG_KD   = 3'd2,
    REG_OLIM = 3'd3,
    REG_ILIM = 3'd4,
    REG_DB   = 3'd5
  } ipid_reg_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] ki;
    logic signed [GAIN_W-1:0] kd;
    logic        [LIM_W-1:0]  olim;
    logic        [LIM_W-1:0]  ilim;
    logic        [DB_W-1:0]   db;
  } ipid_cfg_t;

endpackage

// ----- src/ipid_regs.sv -----
// ipid_regs: APB-style configuration register file for the PID block.
// Depends on ipid_pkg for register codes and the configuration struct.
module ipid_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ipid_pkg::CFG_AW-1:0] paddr,
  input  logic [ipid_pkg::CFG_DW-1:0] pwdata,
  output logic [ipid_pkg::CFG_DW-1:0] prdata,
  output ipid_pkg::ipid_cfg_t         cfg
);
  import ipid_pkg::*;

  ipid_cfg_t cfg_r;
  ipid_cfg_t cfg_nxt;
  ipid_reg_t idx;
  logic      wr_en;

  assign idx   = ipid_reg_t'(paddr[IDX_W+1:2]);
  assign wr_en = psel && penable && pwrite;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_KP:   cfg_nxt.kp   = pwdata[GAIN_W-1:0];
        REG_KI:   cfg_nxt.ki   = pwdata[GAIN_W-1:0];
        REG_KD:   cfg_nxt.kd   = pwdata[GAIN_W-1:0];
        REG_OLIM: cfg_nxt.olim = pwdata[LIM_W-1:0];
        REG_ILIM: cfg_nxt.ilim = pwdata[LIM_W-1:0];
        REG_DB:   cfg_nxt.db   = pwdata[DB_W-1:0];
        default:  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // read mux; gains read back sign-extended
  always_comb begin
    unique case (idx)
      REG_KP:   prdata = CFG_DW'(cfg_r.kp);
      REG_KI:   prdata = CFG_DW'(cfg_r.ki);
      REG_KD:   prdata = CFG_DW'(cfg_r.kd);
      REG_OLIM: prdata = CFG_DW'(cfg_r.olim);
      REG_ILIM: prdata = CFG_DW'(cfg_r.ilim);
      REG_DB:   prdata = CFG_DW'(cfg_r.db);
      default:  prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ----- src/ipid_core.sv -----
// ipid_core: five-stage PID datapath (input, error, products, term sum,
// accumulator) with per-stage valid and back-pressure. Depends on ipid_pkg.
module ipid_core #(
  parameter int FRAC_BITS = ipid_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ipid_pkg::ipid_cfg_t                cfg,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [ipid_pkg::DATA_W-1:0] measured,
  input  logic signed [ipid_pkg::DATA_W-1:0] setpoint,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [ipid_pkg::DATA_W-1:0] drive,
  output logic                               in_deadband
);
  import ipid_pkg::*;

  localparam int ACC_W = DATA_W + FRAC_BITS;
  localparam int CMP_W = D1_W;

  // stage valids and readies
  logic v0_r, v1_r, v2_r, v3_r, v4_r;
  logic rdy0, rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_r || out_ready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign rdy0 = !v0_r || rdy1;

  // stage payloads
  logic signed [DATA_W-1:0] meas_r, sp_r;
  logic signed [ERR_W-1:0]  e1_r, e2_r;      // error history
  logic signed [ERR_W-1:0]  err_r;
  logic signed [D1_W-1:0]   d1_r;
  logic signed [D2_W-1:0]   d2_r;
  logic                     ins1_r, ins2_r, ins3_r, ins4_r;
  logic signed [P_W-1:0]    p_r;
  logic signed [I_W-1:0]    i_r;
  logic signed [D_W-1:0]    d_r;
  logic signed [SUM_W-1:0]  pid_r;
  logic signed [ACC_W-1:0]  acc_r;

  // stage 1: error, differences, deadband test
  logic signed [ERR_W-1:0]  err_nxt;
  logic signed [D1_W-1:0]   d1_nxt;
  logic signed [D2_W-1:0]   d2_nxt;
  logic signed [CMP_W-1:0]  err_x, db_x;
  logic                     ins_nxt;

  always_comb begin
    err_nxt = ERR_W'(sp_r) - ERR_W'(meas_r);
    d1_nxt  = D1_W'(err_nxt) - D1_W'(e1_r);
    d2_nxt  = D2_W'(err_nxt) - (D2_W'(e1_r) <<< 1) + D2_W'(e2_r);
    err_x   = CMP_W'(err_nxt);
    db_x    = signed'(CMP_W'(cfg.db));
    ins_nxt = !((err_x >= db_x) || (err_x <= -db_x));
  end

  // stage 2: the three gain products
  logic signed [P_W-1:0] p_nxt;
  logic signed [I_W-1:0] i_nxt;
  logic signed [D_W-1:0] d_nxt;

  always_comb begin
    p_nxt = P_W'(cfg.kp) * P_W'(d1_r);
    i_nxt = I_W'(cfg.ki) * I_W'(err_r);
    d_nxt = D_W'(cfg.kd) * D_W'(d2_r);
  end

  // stage 3: clamp integral term, sum the three terms
  logic signed [SUM_W-1:0] ilim, i_x, i_c, pid_nxt;

  always_comb begin
    ilim = signed'(SUM_W'(cfg.ilim)) <<< FRAC_BITS;
    i_x  = SUM_W'(i_r);
    priority if (i_x > ilim) begin
      i_c = ilim;
    end else if (i_x < -ilim) begin
      i_c = -ilim;
    end else begin
      i_c = i_x;
    end
    pid_nxt = SUM_W'(p_r) + i_c + SUM_W'(d_r);
  end

  // stage 4: accumulate and saturate, or clear inside the deadband
  logic signed [SUM_W-1:0] olim, acc_sum, acc_c;
  logic signed [ACC_W-1:0] acc_nxt;

  always_comb begin
    olim    = signed'(SUM_W'(cfg.olim)) <<< FRAC_BITS;
    acc_sum = SUM_W'(acc_r) + pid_r;
    priority if (acc_sum > olim) begin
      acc_c = olim;
    end else if (acc_sum < -olim) begin
      acc_c = -olim;
    end else begin
      acc_c = acc_sum;
    end
    acc_nxt = ins3_r ? '0 : ACC_W'(acc_c);
  end

  // control: valids and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r  <= 1'b0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      e1_r  <= '0;
      e2_r  <= '0;
      acc_r <= '0;
    end else begin
      if (rdy0) v0_r <= in_valid;
      if (rdy1) v1_r <= v0_r;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy1 && v0_r) begin
        e1_r <= err_nxt;
        e2_r <= e1_r;
      end
      if (rdy4 && v3_r) begin
        acc_r <= acc_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (rdy0 && in_valid) begin
      meas_r <= measured;
      sp_r   <= setpoint;
    end
    if (rdy1 && v0_r) begin
      err_r  <= err_nxt;
      d1_r   <= d1_nxt;
      d2_r   <= d2_nxt;
      ins1_r <= ins_nxt;
    end
    if (rdy2 && v1_r) begin
      p_r    <= p_nxt;
      i_r    <= i_nxt;
      d_r    <= d_nxt;
      ins2_r <= ins1_r;
    end
    if (rdy3 && v2_r) begin
      pid_r  <= pid_nxt;
      ins3_r <= ins2_r;
    end
    if (rdy4 && v3_r) begin
      ins4_r <= ins3_r;
    end
  end

  assign in_ready    = rdy0;
  assign out_valid   = v4_r;
  assign drive       = DATA_W'(acc_r >>> FRAC_BITS);
  assign in_deadband = ins4_r;

endmodule

// ----- src/incremental_pid_deadband_top.sv -----
// incremental_pid_deadband_top: incremental PID controller with deadband,
// stream in/out and APB-style configuration. Uses ipid_pkg, ipid_regs, ipid_core.
//
//   channel  | direction | word
//   in_      | slave     | tdata[15:0] measured, tdata[31:16] setpoint
//   out_     | master    | tdata[15:0] drive, tuser[0] in_deadband
//   cfg_     | APB slave | six registers at byte addresses 0x00..0x14
//
// One word per cycle sustained while out_ does not stall; each result passes the input,
// error, product, term-sum and accumulator registers before it is offered on out_.
// The accumulator loop is one add and a saturate per cycle; the three gain multipliers
// sit in their own stage. Reset clears registers, error history and accumulator.
// Stages with no word absorb new input while out_ stalls.
module incremental_pid_deadband_top #(
  parameter int FRAC_BITS = ipid_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input stream
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [31:0]                 in_tdata,   // [15:0] measured, [31:16] setpoint
  // result stream
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [15:0]                 out_tdata,  // [15:0] drive
  output logic                        out_tuser,  // [0] in_deadband
  // configuration
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [ipid_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [ipid_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [ipid_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);
  import ipid_pkg::*;

  ipid_cfg_t                cfg;
  logic signed [DATA_W-1:0] drive;

  assign cfg_pready = 1'b1;

  ipid_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  ipid_core #(
    .FRAC_BITS (FRAC_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .measured    (in_tdata[DATA_W-1:0]),
    .setpoint    (in_tdata[2*DATA_W-1:DATA_W]),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .drive       (drive),
    .in_deadband (out_tuser)
  );

  assign out_tdata = drive;

`ifndef NO_ASSERTIONS
  // a word inside the deadband always drives zero
  a_deadband_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("deadband result with nonzero drive");

  // drive never leaves the saturation bound
  a_drive_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(drive) <= $signed({1'b0, cfg.olim}))
                && ($signed(drive) >= -$signed({1'b0, cfg.olim})))
    else $error("drive outside output limit");

  // input back-pressure only comes from a full pipe with a stalled result
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output back-pressure");
`endif

endmodule

// ----- tb/incremental_pid_deadband_top_test.sv -----
// Self-checking test of incremental_pid_deadband_top: directed words and random control
// sequences, each result compared against a velocity-form PID predictor kept in step here.
// Depends on ipid_pkg and the RTL of incremental_pid_deadband_top.
module incremental_pid_deadband_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ipid_pkg::*;

  localparam int FRAC        = FRAC_BITS_DEF;
  localparam int NUM_REGS    = 6;    // first index past the register map
  localparam int IDLE_LIMIT  = 3000; // cycles with no word moving on either side
  localparam int ERR_PRINTS  = 20;
  localparam int N_PHASES    = 8;
  localparam int PHASE_WORDS = 200;
  localparam int HOLD_AFTER  = 300;  // results seen before the long receiver hold-off
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic signed [DATA_W-1:0] drive;
    logic                     inband;
  } result_t;

  // one register image per directed setting
  typedef struct packed {
    logic [31:0] kp, ki, kd, olim, ilim, db;
  } cfg_words_t;

  // cfg_sel: 0 keeps the current setting, n loads CFG_SETS[n-1] first
  typedef struct packed {
    logic [2:0]               cfg_sel;
    logic signed [DATA_W-1:0] meas;
    logic signed [DATA_W-1:0] sp;
    logic                     known;
    logic signed [DATA_W-1:0] drive;
    logic                     inband;
  } stim_row_t;

  // A: upper bits set in all words but Kd, zero output limit, deadband of 100
  // B: gain extremes, widest limits, zero deadband
  // C: moderate gains and limits, small deadband
  // D: negative Kp and Kd, zero integral limit, widest deadband
  localparam cfg_words_t CFG_SETS [4] = '{
    '{32'hFF01_0000, 32'hAB00_8000, 32'h0000_4000, 32'hFFFF_0000, 32'h0001_0064, 32'hFFFF_0064},
    '{32'h007F_FFFF, 32'h0080_0000, 32'h007F_FFFF, 32'h0000_7FFF, 32'h0000_7FFF, 32'h0000_0000},
    '{32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'd1000,      32'd200,       32'd5},
    '{32'hFFFF_FFFF, 32'h0000_0100, 32'h0080_0000, 32'd500,       32'd0,         32'h0000_FFFF}
  };

  localparam int N_DIRECTED = 24;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    // reset setting: zero gains, zero deadband, so the loop runs but drive stays 0
    '{0, 0, 0, 1, 0, 0},
    '{0, -32768, 32767, 1, 0, 0},
    '{0, 32767, -32768, 1, 0, 0},
    '{0, 100, -100, 1, 0, 0},
    // zero output limit: drive 0, flag tracks the deadband edges
    '{1, 0, 0, 1, 0, 1},
    '{0, 0, 99, 1, 0, 1},
    '{0, 0, 100, 1, 0, 0},
    '{0, 100, 0, 1, 0, 0},
    '{0, 99, 0, 1, 0, 1},
    '{0, 32767, -32768, 1, 0, 0},
    // full-scale swings into saturation
    '{2, -32768, 32767, 0, 0, 0},
    '{0, 32767, -32768, 0, 0, 0},
    '{0, -32768, 32767, 0, 0, 0},
    '{0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0, 0},
    // ordinary steps, one inside the band (clears the accumulator)
    '{3, 0, 10, 0, 0, 0},
    '{0, 0, 12, 0, 0, 0},
    '{0, 0, 3, 0, 0, 0},
    '{0, 0, -20, 0, 0, 0},
    '{0, 5, 0, 0, 0, 0},
    // widest deadband: only full-scale errors get past it
    '{4, 0, 0, 1, 0, 1},
    '{0, -32768, 32767, 0, 0, 0},
    '{0, 32767, -32768, 0, 0, 0},
    '{0, 1, -1, 1, 0, 1}
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [31:0]          in_tdata = '0;   // [15:0] measured, [31:16] setpoint
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [15:0]          out_tdata;       // [15:0] drive
  logic                 out_tuser;       // [0] in_deadband
  logic                 cfg_psel = 1'b0;
  logic                 cfg_penable = 1'b0;
  logic                 cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]    cfg_paddr = '0;
  logic [CFG_DW-1:0]    cfg_pwdata = '0;
  logic [CFG_DW-1:0]    cfg_prdata;
  logic                 cfg_pready;

  incremental_pid_deadband_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // predictor copy of the registers and the loop state
  longint m_kp, m_ki, m_kd, m_olim, m_ilim, m_db;
  longint m_err1, m_err2, m_acc;

  result_t expect_q[$];
  result_t next_expect;
  result_t got_expect;
  bit      cur_known;
  result_t cur_typed;
  bit      calm;
  bit      hold_done;
  int      stall_left;
  int      n_results;
  int      n_errors;
  int      idle_cycles;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clamp_sym(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // one control update: shift error history, then run or clear the accumulator
  function automatic result_t pid_model_step(input logic signed [DATA_W-1:0] meas,
                                             input logic signed [DATA_W-1:0] sp);
    logic signed [ERR_W-1:0] err_w;
    longint err, e1, e2, p_term, i_term, d_term;
    result_t r;
    err_w = sp - meas;
    err = err_w;
    e1 = m_err1;
    e2 = m_err2;
    m_err2 = m_err1;
    m_err1 = err;
    r.inband = !(err >= m_db || err <= -m_db);
    if (!r.inband) begin
      p_term = m_kp * (err - e1);
      i_term = clamp_sym(m_ki * err, m_ilim <<< FRAC);
      d_term = m_kd * (err - 2 * e1 + e2);
      m_acc = clamp_sym(m_acc + p_term + i_term + d_term, m_olim <<< FRAC);
    end else begin
      m_acc = 0;
    end
    r.drive = DATA_W'(m_acc >>> FRAC);  // arithmetic shift floors
    return r;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] rand_gain();
    logic [31:0] g;
    case ($urandom_range(0, 5))
      0:       g = $urandom;
      1, 2:    g = $urandom_range(0, 32'h4_0000) - 32'h2_0000;  // within +/-2.0
      3:       g = 32'h007F_FFFF;
      4:       g = 32'h0080_0000;
      default: g = 32'h0;
    endcase
    g[31:GAIN_W] = (32-GAIN_W)'($urandom);
    return g;
  endfunction

  function automatic logic [31:0] rand_limit();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0:       v = 0;
      1:       v = 32'h7FFF;
      2:       v = $urandom_range(1, 100);
      default: v = $urandom_range(0, 32767);
    endcase
    v[31:LIM_W] = (32-LIM_W)'($urandom);
    return v;
  endfunction

  function automatic logic [31:0] rand_deadband();
    logic [31:0] v;
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) v = 0;
    else if (r == 1) v = 32'hFFFF;
    else if (r < 8) v = $urandom_range(1, 300);
    else v = $urandom_range(0, 65535);
    v[31:DB_W] = (32-DB_W)'($urandom);
    return v;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat16(input int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return DATA_W'(v);
  endfunction

  // register write over the APB port; entered and left at a falling edge
  task automatic apb_write(input logic [IDX_W-1:0] idx, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_KP:   m_kp   = longint'(signed'(val[GAIN_W-1:0]));
      REG_KI:   m_ki   = longint'(signed'(val[GAIN_W-1:0]));
      REG_KD:   m_kd   = longint'(signed'(val[GAIN_W-1:0]));
      REG_OLIM: m_olim = longint'(val[LIM_W-1:0]);
      REG_ILIM: m_ilim = longint'(val[LIM_W-1:0]);
      REG_DB:   m_db   = longint'(val[DB_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic load_cfg(input cfg_words_t c);
    apb_write(REG_KP, c.kp);
    apb_write(REG_KI, c.ki);
    apb_write(REG_KD, c.kd);
    apb_write(REG_OLIM, c.olim);
    apb_write(REG_ILIM, c.ilim);
    apb_write(REG_DB, c.db);
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    in_tvalid <= 1'b0;
    while (expect_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // offer one word after an optional gap; returns at the falling edge after acceptance
  task automatic send_word(input logic signed [DATA_W-1:0] meas,
                           input logic signed [DATA_W-1:0] sp,
                           input bit known, input result_t typed);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {sp, meas};
    cur_known = known;
    cur_typed = typed;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // random setting, then a mix of tracking sequences and noise
  task automatic random_phase(input int n_words);
    int sp_track, span, r;
    logic signed [DATA_W-1:0] meas, sp;
    cfg_words_t c;
    c.kp   = rand_gain();
    c.ki   = rand_gain();
    c.kd   = rand_gain();
    c.olim = rand_limit();
    c.ilim = rand_limit();
    c.db   = rand_deadband();
    load_cfg(c);
    apb_write(IDX_W'(NUM_REGS), $urandom);      // unmapped addresses are ignored
    apb_write(IDX_W'(NUM_REGS + 1), $urandom);
    sp_track = $urandom_range(0, 4000) - 2000;
    for (int k = 0; k < n_words; k++) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        meas = DATA_W'($urandom);
        sp   = DATA_W'($urandom);
      end else begin
        if (r < 25) sp_track = $urandom_range(0, 65535) - 32768;
        else if (r < 40) sp_track = sat16(sp_track + $urandom_range(0, 400) - 200);
        span = (m_db > 2000 ? 2000 : int'(m_db)) + 20;
        sp   = sat16(sp_track);
        meas = sat16(sp_track + $urandom_range(0, 2 * span) - span);
      end
      send_word(meas, sp, 1'b0, '0);
    end
    drain();
  endtask

  // predict each accepted word; typed rows override the prediction
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      next_expect = pid_model_step(signed'(in_tdata[15:0]), signed'(in_tdata[31:16]));
      if (cur_known) next_expect = cur_typed;
      expect_q.push_back(next_expect);
    end
  end

  // compare each result word with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (expect_q.size() == 0) begin
        n_errors++;
        if (n_errors <= ERR_PRINTS)
          $display("%0t: unexpected result word, expected none, got drive %0d in_deadband %0b",
                   $time, $signed(out_tdata), out_tuser);
      end else begin
        got_expect = expect_q.pop_front();
        if (out_tdata !== got_expect.drive) begin
          n_errors++;
          if (n_errors <= ERR_PRINTS)
            $display("%0t: drive mismatch, expected %0d, got %0d",
                     $time, got_expect.drive, $signed(out_tdata));
        end
        if (out_tuser !== got_expect.inband) begin
          n_errors++;
          if (n_errors <= ERR_PRINTS)
            $display("%0t: in_deadband mismatch, expected %0b, got %0b",
                     $time, got_expect.inband, out_tuser);
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold-off so the pipeline backs up
  always @(negedge clk) begin
    if (!hold_done && n_results >= HOLD_AFTER) begin
      hold_done = 1'b1;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    stim_row_t row;
    result_t   typed;
    m_kp = 0; m_ki = 0; m_kd = 0; m_olim = 0; m_ilim = 0; m_db = 0;
    m_err1 = 0; m_err2 = 0; m_acc = 0;
    calm = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    for (int k = 0; k < N_DIRECTED; k++) begin
      row = DIRECTED[k];
      if (row.cfg_sel != 0) begin
        drain();
        load_cfg(CFG_SETS[row.cfg_sel - 1]);
      end
      typed.drive  = row.drive;
      typed.inband = row.inband;
      send_word(row.meas, row.sp, row.known, typed);
    end
    drain();

    // random settings; every third phase runs without gaps on either side
    for (int ph = 0; ph < N_PHASES; ph++) begin
      calm = (ph % 3 == 1);
      random_phase(PHASE_WORDS);
    end
    calm = 1'b0;

    repeat (10) @(posedge clk);
    if (n_errors == 0 && expect_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/ipid_pkg.sv
src/ipid_regs.sv
src/ipid_core.sv
src/incremental_pid_deadband_top.sv
tb/incremental_pid_deadband_top_test.sv
